FILE: hdl/miu_pkg.sv
// ----------------------------------------------------------------------------
// miu_pkg
// Shared types and constants of the modular inverse unit: field widths,
// controller states, and the command and status bundles.
// ----------------------------------------------------------------------------
package miu_pkg;

  localparam int unsigned FIELD_W = 31;
  localparam logic [FIELD_W-1:0] MODULUS_RESET = 31'h7FFF_FFFF;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CHECK = 6'b000010,
    ST_ALIGN = 6'b000100,
    ST_SUB   = 6'b001000,
    ST_FIX   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  // Commands from controller to datapath; at most one is high per cycle.
  typedef struct packed {
    logic load;      // start a transaction: r = p, nr = value, t = 0, nt = 1
    logic init;      // open one Euclid step
    logic shift;     // double the shifted divisor and coefficient
    logic sub;       // one quotient bit; closes the step when the shift count is zero
    logic fix;       // bring a negative coefficient up by the modulus
    logic out_load;  // write the result register
  } cmd_t;

  typedef struct packed {
    logic nr_zero;   // Euclid loop has finished
    logic can_shift; // doubled divisor still fits under the remainder
    logic k_zero;    // last quotient bit of the current step
  } sts_t;

endpackage

FILE: hdl/miu_ctrl.sv
// ----------------------------------------------------------------------------
// miu_ctrl
// Sequencer of the modular inverse unit: walks the Euclid steps, the
// coefficient fix-up and the result hand-off.
// ----------------------------------------------------------------------------
module miu_ctrl import miu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.nr_zero) begin
          state_d = ST_FIX;
        end else begin
          cmd_o.init = 1'b1;
          state_d    = ST_ALIGN;
        end
      end
      ST_ALIGN: begin
        if (sts_i.can_shift) begin
          cmd_o.shift = 1'b1;
        end else begin
          state_d = ST_SUB;
        end
      end
      ST_SUB: begin
        cmd_o.sub = 1'b1;
        if (sts_i.k_zero) begin
          state_d = ST_CHECK;
        end
      end
      ST_FIX: begin
        cmd_o.fix = 1'b1;
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        // Hold the result until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: hdl/miu_datapath.sv
// ----------------------------------------------------------------------------
// miu_datapath
// Euclid registers with a shift-subtract quotient unit that updates the
// Bezout coefficient alongside the remainder, plus the result register.
// ----------------------------------------------------------------------------
module miu_datapath import miu_pkg::*; #(
  parameter int unsigned DW = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [FIELD_W-1:0] cfg_wdata_i,
  input  logic [FIELD_W-1:0] value_i,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  output logic [FIELD_W-1:0] inverse_o,
  output logic               no_inverse_o
);

  localparam int unsigned TW = DW + 2;
  localparam int unsigned KW = $clog2(DW);

  logic [FIELD_W-1:0]   mod_q;
  logic [DW-1:0]        r_q, nr_q, rem_q, dsh_q;
  logic signed [TW-1:0] t_q, nt_q, acc_q, tsh_q;
  logic [KW-1:0]        k_q;
  logic [FIELD_W-1:0]   inverse_q;
  logic                 no_inv_q;

  logic [DW-1:0]        mod_ext, value_ext, rem_sub;
  logic signed [TW-1:0] mod_t, acc_sub, fix_val, out_val;
  logic                 sub_ok, no_inv_next;

  assign mod_ext   = {{(DW-FIELD_W){1'b0}}, mod_q};
  assign value_ext = {{(DW-FIELD_W){1'b0}}, value_i};
  assign mod_t     = $signed({{(TW-FIELD_W){1'b0}}, mod_q});

  assign sts_o.nr_zero   = (nr_q == '0);
  assign sts_o.can_shift = ({dsh_q, 1'b0} <= {1'b0, rem_q});
  assign sts_o.k_zero    = (k_q == '0);

  assign sub_ok  = (rem_q >= dsh_q);
  assign rem_sub = sub_ok ? (rem_q - dsh_q) : rem_q;
  assign acc_sub = sub_ok ? (acc_q - tsh_q) : acc_q;

  assign fix_val = t_q[TW-1] ? (t_q + mod_t) : t_q;
  // Coefficient may equal the modulus; fold it back. A zero modulus leaves it.
  assign out_val = ((mod_q != '0) && (acc_q >= mod_t)) ? (acc_q - mod_t) : acc_q;
  assign no_inv_next = (r_q != {{(DW-1){1'b0}}, 1'b1});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= MODULUS_RESET;
    end else if (cfg_we_i) begin
      mod_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (cmd_i.load) begin
      r_q  <= mod_ext;
      nr_q <= value_ext;
      t_q  <= '0;
      nt_q <= {{(TW-1){1'b0}}, 1'b1};
    end else if (cmd_i.init) begin
      rem_q <= r_q;
      acc_q <= t_q;
      dsh_q <= nr_q;
      tsh_q <= nt_q;
      k_q   <= '0;
    end else if (cmd_i.shift) begin
      dsh_q <= {dsh_q[DW-2:0], 1'b0};
      tsh_q <= tsh_q <<< 1;
      k_q   <= k_q + 1'b1;
    end else if (cmd_i.sub) begin
      rem_q <= rem_sub;
      acc_q <= acc_sub;
      if (k_q == '0) begin
        r_q  <= nr_q;
        nr_q <= rem_sub;
        t_q  <= nt_q;
        nt_q <= acc_sub;
      end else begin
        dsh_q <= {1'b0, dsh_q[DW-1:1]};
        tsh_q <= tsh_q >>> 1;
        k_q   <= k_q - 1'b1;
      end
    end else if (cmd_i.fix) begin
      acc_q <= fix_val;
    end else if (cmd_i.out_load) begin
      no_inv_q  <= no_inv_next;
      inverse_q <= no_inv_next ? '0 : out_val[FIELD_W-1:0];
    end
  end

  assign inverse_o    = inverse_q;
  assign no_inverse_o = no_inv_q;

endmodule

FILE: hdl/modular_inverse_unit.sv
// ----------------------------------------------------------------------------
// modular_inverse_unit
// Run time grows with the quotients of the Euclid steps, each retired by the
//   shift-subtract quotient loop.
// Transactions: one at a time; a new one enters only from idle, after the
//   previous result has been written to the result register. The next
//   transaction enters while a result waits.
// Reset: asynchronous, active low; modulus returns to 2^31-1, no result held.
// ----------------------------------------------------------------------------
module modular_inverse_unit import miu_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Modulus register write
  input  logic               cfg_we_i,
  input  logic [FIELD_W-1:0] cfg_wdata_i,
  // Input channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [FIELD_W-1:0] value_i,
  // Result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [FIELD_W-1:0] inverse_o,
  output logic               no_inverse_o
);

  // The Euclid registers must hold 31-bit values plus one bit of headroom for
  // the doubled divisor compare; narrower settings widen to that.
  localparam int unsigned DW = (DATA_WIDTH < 32) ? 32 : DATA_WIDTH;

  cmd_t cmd;
  sts_t sts;

  // Controller: one-hot sequencer over idle, check, align, subtract, fix-up, done.
  miu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: each Euclid step aligns the divisor to the remainder, then
  // retires one quotient bit a cycle, subtracting the shifted divisor from
  // the remainder and the shifted coefficient from the running Bezout term.
  // The final coefficient is lifted into 0..p-1 and a gcd other than one
  // drops the result to zero with the flag raised.
  miu_datapath #(
    .DW (DW)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .value_i      (value_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .inverse_o    (inverse_o),
    .no_inverse_o (no_inverse_o)
  );

endmodule
